// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helper functions of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Heap geometry
    localparam int LEVELS    = 10;
    localparam int MIN_SHIFT = 5;
    localparam int MIN_BLOCK = 1 << MIN_SHIFT;
    localparam int IW        = LEVELS - 1;          // block index bits
    localparam int NBLK      = 1 << IW;
    localparam int SAW       = IW + 1;              // free entry store address bits
    localparam int CW        = IW + 1;              // level count bits (holds NBLK)
    localparam int LW        = $clog2(LEVELS + 1);  // level number, may hold LEVELS
    localparam int LIW       = $clog2(LEVELS);      // level count array index
    localparam int ORDER_W   = 4;
    localparam logic [32:0] HEAP_BYTES = 33'(longint'(MIN_BLOCK) << (LEVELS - 1));
    localparam logic [SAW-1:0] TOP_ADDR = SAW'(2 * NBLK - 2);

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_NULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_ASCAN, S_APOP, S_SPLIT,
        S_FRD, S_FCHK, S_TSCAN, S_TCMP, S_SHRD, S_SHWR, S_FPUSH, S_DONE
    } t_state;

    typedef struct packed {
        logic           we;
        logic [SAW-1:0] waddr;
        logic [IW-1:0]  wdata;
        logic           re;
        logic [SAW-1:0] raddr;
    } t_store_req;

    typedef struct packed {
        logic               we;
        logic [IW-1:0]      waddr;
        logic [ORDER_W-1:0] wdata;
        logic               re;
        logic [IW-1:0]      raddr;
    } t_ord_req;

    typedef struct packed {
        t_status            status;
        logic [31:0]        address;
        logic [ORDER_W-1:0] order;
    } t_result;

    // First store entry of level l
    function automatic logic [SAW-1:0] lvl_base(input logic [LIW-1:0] l);
        return SAW'(2 * NBLK - 2 * (NBLK >> l));
    endfunction

    // Entry capacity of level l
    function automatic logic [CW-1:0] lvl_cap(input logic [LIW-1:0] l);
        return CW'(NBLK >> l);
    endfunction

    // Smallest order whose block holds max(size, MIN_BLOCK) plus a header byte
    function automatic logic [LW-1:0] alloc_order(input logic [15:0] size);
        logic [16:0] need;
        logic [LW-1:0] k;
        need = (size < 16'(MIN_BLOCK)) ? 17'(MIN_BLOCK) : {1'b0, size};
        need = need + 17'd1;
        k = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if ((longint'(MIN_BLOCK) << j) < longint'(need)) begin
                k = k + LW'(1);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/buddy_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a heap of LEVELS orders of MIN_BLOCK-sized units.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready): i_mode selects allocate or
//   free; i_request_size is the byte count to allocate, i_block_address the
//   address to free. One transaction in gives exactly one response
//   transaction on o_out_valid / i_out_ready carrying status, address, order.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
//   heap base; write it only while the block is idle.
//   Allocate scans the levels upward from the requested order, pops a free
//   entry and splits it down to that order; free reads the block's order,
//   then per level searches the free list for the buddy, removes it by
//   moving the later entries down and merges, and finally pushes the block.
//   Each step makes at most one access of the free entry store.
//   One request is in flight at a time; o_in_ready is low while it runs.
//   A finished response sits in an output register, so a stalled receiver
//   holds only that response; the next request is taken meanwhile, and input
//   stalls once that one has finished too.
//   Reset: the top level holds the whole heap as one free block, other levels
//   are empty, heap base is zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [15:0] i_request_size,
    input  logic [31:0] i_block_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_address,
    output logic [3:0]  o_order,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import bba_pkg::*;

    logic [31:0]   r_heap_base;
    t_store_req    store_req;
    logic [IW-1:0] store_rdata;
    t_ord_req      ord_req;
    logic [ORDER_W-1:0] ord_rdata;
    logic          res_vld;
    logic          res_take;
    t_result       res;
    logic          r_out_vld;
    t_result       r_out;

    // Config register: always accepted
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
        end else if (i_cfg_valid) begin
            r_heap_base <= i_cfg_data;
        end
    end

    bba_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_mode          (i_mode),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_heap_base     (r_heap_base),
        .o_store_req     (store_req),
        .i_store_rdata   (store_rdata),
        .o_ord_req       (ord_req),
        .i_ord_rdata     (ord_rdata),
        .o_res_vld       (res_vld),
        .i_res_take      (res_take),
        .o_res           (res)
    );

    bba_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rdata (store_rdata)
    );

    bba_ord u_ord (
        .i_clk   (i_clk),
        .i_req   (ord_req),
        .o_rdata (ord_rdata)
    );

    // Output register: load when empty or being drained
    assign res_take = res_vld && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out.status;
    assign o_address   = r_out.address;
    assign o_order     = r_out.order;

    // A taken request blocks the next until its response is loaded into the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while busy");

    a_null_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NULL) |-> (o_address == 32'd0 && o_order == 4'd0))
        else $error("ignored free carries payload");

    a_oom_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OOM) |-> (o_address == 32'd0 && o_order == 4'd0))
        else $error("out of memory carries payload");

    a_one_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |-> res_vld && !(r_out_vld && !i_out_ready))
        else $error("response overwrote a pending one");

endmodule

// ===== rtl/bba_store.sv =====
// ----------------------------------------------------------------------------
// bba_store
// Free entry store: one stack region per level, one write and one
// registered read port. The top level's first entry reads zero until written.
// ----------------------------------------------------------------------------
module bba_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bba_pkg::t_store_req      i_req,
    output logic [bba_pkg::IW-1:0]   o_rdata
);
    import bba_pkg::*;

    logic [IW-1:0] r_mem [2*NBLK];
    logic [IW-1:0] r_q;
    logic          r_top_vld;
    logic          r_rd_blank;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_vld  <= 1'b0;
            r_rd_blank <= 1'b0;
        end else begin
            if (i_req.we && i_req.waddr == TOP_ADDR) begin
                r_top_vld <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_blank <= (i_req.raddr == TOP_ADDR) && !r_top_vld;
            end
        end
    end

    assign o_rdata = r_rd_blank ? '0 : r_q;

endmodule

// ===== rtl/bba_ord.sv =====
// ----------------------------------------------------------------------------
// bba_ord
// Block order table: order recorded for each allocated block.
// ----------------------------------------------------------------------------
module bba_ord (
    input  logic                        i_clk,
    input  bba_pkg::t_ord_req           i_req,
    output logic [bba_pkg::ORDER_W-1:0] o_rdata
);
    import bba_pkg::*;

    logic [ORDER_W-1:0] r_mem [NBLK];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: level scan, pop and split for allocation; buddy search,
// removal and merge for free. At most one store access per step.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic [15:0]                 i_request_size,
    input  logic [31:0]                 i_block_address,
    input  logic [31:0]                 i_heap_base,
    output bba_pkg::t_store_req         o_store_req,
    input  logic [bba_pkg::IW-1:0]      i_store_rdata,
    output bba_pkg::t_ord_req           o_ord_req,
    input  logic [bba_pkg::ORDER_W-1:0] i_ord_rdata,
    output logic                        o_res_vld,
    input  logic                        i_res_take,
    output bba_pkg::t_result            o_res
);
    import bba_pkg::*;

    t_state        r_state, n_state;
    logic [LW-1:0] r_k, n_k;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_buddy, n_buddy;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_cnt [LEVELS];
    logic [CW-1:0] n_cnt [LEVELS];
    t_result       r_res, n_res;

    logic           acc;
    logic [LIW-1:0] cur;
    logic [LIW-1:0] dn;
    logic [CW-1:0]  cnt_cur;
    logic [CW-1:0]  cnt_dn;
    logic [31:0]    off;
    logic           bad_free;
    logic [ORDER_W-1:0] k0;

    assign acc      = i_valid && (r_state == S_IDLE);
    assign o_ready  = (r_state == S_IDLE);
    assign o_res_vld = (r_state == S_DONE);
    assign o_res    = r_res;

    assign cur     = r_lvl[LIW-1:0];
    assign dn      = cur - LIW'(1);
    assign cnt_cur = (r_lvl < LW'(LEVELS)) ? r_cnt[cur] : '0;
    assign cnt_dn  = r_cnt[dn];

    assign off      = i_block_address - 32'd1 - i_heap_base;
    assign bad_free = (i_block_address == 32'd0) || ({1'b0, off} >= HEAP_BYTES)
                    || (off[MIN_SHIFT-1:0] != '0);
    assign k0 = (32'(i_ord_rdata) >= 32'(LEVELS)) ? ORDER_W'(LEVELS - 1) : i_ord_rdata;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_mode == MODE_ALLOC) n_state = S_ASCAN;
                    else if (bad_free)        n_state = S_DONE;
                    else                      n_state = S_FRD;
                end
            end
            S_ASCAN: begin
                if (r_lvl >= LW'(LEVELS)) n_state = S_DONE;
                else if (cnt_cur != '0)   n_state = S_APOP;
            end
            S_APOP:  n_state = S_SPLIT;
            S_SPLIT: begin
                if (r_lvl <= r_k) n_state = S_DONE;
            end
            S_FRD:   n_state = S_FCHK;
            S_FCHK: begin
                n_state = (r_lvl < LW'(LEVELS - 1)) ? S_TSCAN : S_FPUSH;
            end
            S_TSCAN: n_state = (r_i == '0) ? S_FPUSH : S_TCMP;
            S_TCMP:  n_state = (i_store_rdata == r_buddy) ? S_SHRD : S_TSCAN;
            S_SHRD: begin
                n_state = ((CW+1)'(r_j) + (CW+1)'(1) < (CW+1)'(cnt_cur)) ? S_SHWR : S_FCHK;
            end
            S_SHWR:  n_state = S_SHRD;
            S_FPUSH: n_state = S_DONE;
            S_DONE: begin
                if (i_res_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb begin
        n_k     = r_k;
        n_lvl   = r_lvl;
        n_idx   = r_idx;
        n_buddy = r_buddy;
        n_i     = r_i;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_res   = r_res;
        o_store_req = '0;
        o_ord_req   = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_k   = alloc_order(i_request_size);
                    n_lvl = alloc_order(i_request_size);
                    if (i_mode == MODE_FREE) begin
                        n_idx = off[MIN_SHIFT +: IW];
                        if (bad_free) begin
                            n_res = '{status: ST_NULL, address: '0, order: '0};
                        end else begin
                            o_ord_req.re    = 1'b1;
                            o_ord_req.raddr = off[MIN_SHIFT +: IW];
                        end
                    end
                end
            end
            S_ASCAN: begin
                if (r_lvl >= LW'(LEVELS)) begin
                    n_res = '{status: ST_OOM, address: '0, order: '0};
                end else if (cnt_cur == '0) begin
                    n_lvl = r_lvl + LW'(1);
                end else begin
                    n_cnt[cur]        = cnt_cur - CW'(1);
                    o_store_req.re    = 1'b1;
                    o_store_req.raddr = lvl_base(cur) + SAW'(cnt_cur - CW'(1));
                end
            end
            S_APOP: n_idx = i_store_rdata;
            S_SPLIT: begin
                if (r_lvl > r_k) begin
                    // hand the upper half back one level down
                    n_lvl = r_lvl - LW'(1);
                    if (cnt_dn < lvl_cap(dn)) begin
                        o_store_req.we    = 1'b1;
                        o_store_req.waddr = lvl_base(dn) + SAW'(cnt_dn);
                        o_store_req.wdata = r_idx + (IW'(1) << dn);
                        n_cnt[dn]         = cnt_dn + CW'(1);
                    end
                end else begin
                    o_ord_req.we    = 1'b1;
                    o_ord_req.waddr = r_idx;
                    o_ord_req.wdata = ORDER_W'(r_k);
                    n_res = '{status: ST_OK,
                              address: i_heap_base + (32'(r_idx) << MIN_SHIFT) + 32'd1,
                              order: ORDER_W'(r_k)};
                end
            end
            S_FRD: begin
                n_k   = LW'(k0);
                n_lvl = LW'(k0);
            end
            S_FCHK: begin
                n_buddy = r_idx ^ (IW'(1) << cur);
                n_i     = cnt_cur;
            end
            S_TSCAN: begin
                if (r_i != '0) begin
                    n_i               = r_i - CW'(1);
                    o_store_req.re    = 1'b1;
                    o_store_req.raddr = lvl_base(cur) + SAW'(r_i - CW'(1));
                end
            end
            S_TCMP: begin
                n_j = r_i;
            end
            S_SHRD: begin
                if ((CW+1)'(r_j) + (CW+1)'(1) < (CW+1)'(cnt_cur)) begin
                    o_store_req.re    = 1'b1;
                    o_store_req.raddr = lvl_base(cur) + SAW'(r_j) + SAW'(1);
                end else begin
                    // buddy removed: merge and climb one level
                    n_cnt[cur] = cnt_cur - CW'(1);
                    if (r_buddy < r_idx) n_idx = r_buddy;
                    n_lvl = r_lvl + LW'(1);
                end
            end
            S_SHWR: begin
                o_store_req.we    = 1'b1;
                o_store_req.waddr = lvl_base(cur) + SAW'(r_j);
                o_store_req.wdata = i_store_rdata;
                n_j               = r_j + CW'(1);
            end
            S_FPUSH: begin
                if (cnt_cur < lvl_cap(cur)) begin
                    o_store_req.we    = 1'b1;
                    o_store_req.waddr = lvl_base(cur) + SAW'(cnt_cur);
                    o_store_req.wdata = r_idx;
                    n_cnt[cur]        = cnt_cur + CW'(1);
                end
                n_res = '{status: ST_OK, address: '0, order: ORDER_W'(r_k)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int l = 0; l < LEVELS; l++) begin
                r_cnt[l] <= (l == LEVELS - 1) ? CW'(1) : '0;
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_lvl   <= n_lvl;
        r_idx   <= n_idx;
        r_buddy <= n_buddy;
        r_i     <= n_i;
        r_j     <= n_j;
        r_res   <= n_res;
    end

endmodule

// ===== dv/buddy_block_allocator_core_test.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_test
// Checks the buddy block allocator against a behavioral allocator model:
// directed allocate/free corner cases, heap base changes, and random
// allocate/free traffic with random idling and a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module buddy_block_allocator_core_test;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_mode;
    logic [15:0] i_request_size;
    logic [31:0] i_block_address;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_status;
    logic [31:0] o_address;
    logic [3:0]  o_order;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    buddy_block_allocator_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_address       (o_address),
        .o_order         (o_order),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Allocator model state
    logic [IW-1:0]      lvl_lists [LEVELS][$];
    logic [ORDER_W-1:0] blk_order [NBLK];
    logic [31:0]        heap_start;

    t_result            pending_results [$];
    logic [31:0]        live_blocks [$];
    int                 error_count;
    int                 cycle_count;
    bit                 stall_mode;      // receiver long hold-off
    bit                 idle_enable;

    task automatic model_reset();
        for (int k = 0; k < LEVELS; k++) lvl_lists[k] = {};
        lvl_lists[LEVELS-1].push_back('0);
        for (int i = 0; i < NBLK; i++) blk_order[i] = '0;
        heap_start = '0;
    endtask

    function automatic void list_push(int k, logic [IW-1:0] idx);
        if (lvl_lists[k].size() < (NBLK >> k)) lvl_lists[k].push_back(idx);
    endfunction

    // Compute the result of one request and update the model
    function automatic t_result allocate_or_free(logic mode, logic [15:0] size,
                                                 logic [31:0] addr);
        t_result       res;
        int            need;
        int            k;
        int            lvl;
        int            k0;
        logic [IW-1:0] idx;
        logic [IW-1:0] buddy;
        logic [31:0]   off;
        bit            found;
        res = '{status: ST_OK, address: '0, order: '0};
        if (mode == MODE_ALLOC) begin
            need = (int'(size) < MIN_BLOCK) ? MIN_BLOCK : int'(size);
            need = need + 1;
            k = 0;
            while ((MIN_BLOCK << k) < need && k < LEVELS) k++;
            lvl = k;
            while (lvl < LEVELS && lvl_lists[lvl].size() == 0) lvl++;
            if (lvl >= LEVELS) begin
                res.status = ST_OOM;
                return res;
            end
            idx = lvl_lists[lvl].pop_back();
            while (lvl > k) begin
                lvl--;
                list_push(lvl, idx + (IW'(1) << lvl));
            end
            blk_order[idx] = ORDER_W'(k);
            res.address = heap_start + 32'(idx) * MIN_BLOCK + 32'd1;
            res.order = ORDER_W'(k);
            return res;
        end
        if (addr == 0) begin
            res.status = ST_NULL;
            return res;
        end
        off = addr - 32'd1 - heap_start;
        if (off >= HEAP_BYTES || off % MIN_BLOCK != 0) begin
            res.status = ST_NULL;
            return res;
        end
        idx = IW'(off / MIN_BLOCK);
        k0 = int'(blk_order[idx]);
        if (k0 >= LEVELS) k0 = LEVELS - 1;
        k = k0;
        while (k < LEVELS - 1) begin
            buddy = idx ^ (IW'(1) << k);
            found = 0;
            // drop the entry nearest the head that matches
            for (int i = lvl_lists[k].size() - 1; i >= 0; i--) begin
                if (lvl_lists[k][i] == buddy) begin
                    lvl_lists[k].delete(i);
                    found = 1;
                    break;
                end
            end
            if (!found) break;
            if (buddy < idx) idx = buddy;
            k++;
        end
        list_push(k, idx);
        res.order = ORDER_W'(k0);
        return res;
    endfunction

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("buddy_block_allocator_core verification failed");
            $finish;
        end
    end

    // Receiver: random ready with an optional long hold-off
    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_mode && stall_left == 0) begin
            stall_left <= 300;
            i_out_ready <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (stall_left == 1 && !stall_mode) stall_left <= 0;
            if (!idle_enable) i_out_ready <= 1'b1;
            else if ($urandom_range(0, 19) == 0) i_out_ready <= 1'b0;
            else i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d address %h order %0d",
                         $time, o_status, o_address, o_order);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_address !== want.address) begin
                    $display("%0t: address expected %h actual %h",
                             $time, want.address, o_address);
                    error_count++;
                end
                if (o_order !== want.order) begin
                    $display("%0t: order expected %0d actual %0d",
                             $time, want.order, o_order);
                    error_count++;
                end
            end
        end
    end

    // Offer one request after an optional gap; hold it until accepted
    task automatic send_request(logic mode, logic [15:0] size, logic [31:0] addr);
        int gap;
        t_result res;
        if (idle_enable) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                              : $urandom_range(0, 2);
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_request_size  <= size;
        i_block_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        res = allocate_or_free(mode, size, addr);
        pending_results.push_back(res);
        if (mode == MODE_ALLOC && res.status == ST_OK) live_blocks.push_back(res.address);
        i_in_valid <= 1'b0;
        // the block is busy after an accept anyway
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_heap_base(logic [31:0] base);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= base;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        heap_start = base;
    endtask

    // Free every outstanding block so the heap is whole again
    task automatic free_all();
        while (live_blocks.size() != 0)
            send_request(MODE_FREE, 16'($urandom), live_blocks.pop_front());
    endtask

    task automatic test_directed_corners();
        send_request(MODE_ALLOC, 16'd0, 32'd0);
        send_request(MODE_ALLOC, 16'd31, 32'd0);
        send_request(MODE_ALLOC, 16'd32, 32'd0);
        send_request(MODE_ALLOC, 16'd63, 32'd0);
        send_request(MODE_ALLOC, 16'd64, 32'd0);
        send_request(MODE_ALLOC, 16'hFFFF, 32'd0);   // too large
        send_request(MODE_ALLOC, 16'd8191, 32'd0);   // half heap order
        send_request(MODE_FREE, 16'hFFFF, 32'd0);    // null free
        send_request(MODE_FREE, 16'd0, 32'hFFFF_FFFF); // outside heap
        send_request(MODE_FREE, 16'd0, 32'd2);         // off boundary
        free_all();
        send_request(MODE_ALLOC, 16'd8000, 32'd0);     // half the heap
        send_request(MODE_ALLOC, 16'd0, 32'd0);        // smallest block, from the remaining half
        free_all();
    endtask

    task automatic test_heap_base(logic [31:0] base);
        write_heap_base(base);
        for (int i = 0; i < 6; i++) send_request(MODE_ALLOC, 16'($urandom_range(0, 700)), 0);
        send_request(MODE_FREE, 16'd0, base);          // just below block zero
        free_all();
    endtask

    task automatic test_random_traffic(int count);
        int pick;
        logic [31:0] a;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                if ($urandom_range(0, 9) == 0) a = 32'($urandom);
                else a = 32'($urandom_range(0, 1200));
                send_request(MODE_ALLOC, ($urandom_range(0, 30) == 0) ? 16'($urandom) : a[15:0],
                             32'($urandom));
            end else if (pick < 88 && live_blocks.size() != 0) begin
                a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                foreach (live_blocks[j]) if (live_blocks[j] == a) begin
                    live_blocks.delete(j);
                    break;
                end
                send_request(MODE_FREE, 16'($urandom), a);
            end else begin
                // bad addresses: null, unaligned, or outside the heap
                case ($urandom_range(0, 2))
                    0: a = 32'd0;
                    1: a = heap_start + 32'(($urandom_range(0, NBLK - 1) * MIN_BLOCK))
                           + 32'($urandom_range(2, MIN_BLOCK));
                    default: a = heap_start + 32'd1 + 32'(HEAP_BYTES)
                                 + 32'($urandom_range(0, 1 << 20)) * MIN_BLOCK;
                endcase
                send_request(MODE_FREE, 16'($urandom), a);
            end
        end
        free_all();
    endtask

    task automatic test_output_stall();
        stall_mode = 1;
        for (int i = 0; i < 8; i++) send_request(MODE_ALLOC, 16'($urandom_range(0, 200)), 0);
        stall_mode = 0;
        free_all();
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        stall_mode = 0;
        idle_enable = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = MODE_ALLOC;
        i_request_size = '0;
        i_block_address = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        model_reset();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        idle_enable = 1;
        test_heap_base(32'hFFFF_C000);   // heap ends at the top of the space
        test_heap_base(32'h8000_4000);
        test_output_stall();
        test_random_traffic(140);
        write_heap_base(32'h0000_0000);
        idle_enable = 0;
        test_random_traffic(50);
        idle_enable = 1;
        write_heap_base(32'h1234_4000);
        test_random_traffic(120);
        drain();

        if (error_count == 0) begin
            $display("buddy_block_allocator_core verification clean");
        end else begin
            $display("buddy_block_allocator_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bba_pkg.sv
rtl/bba_store.sv
rtl/bba_ord.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_core.sv
dv/buddy_block_allocator_core_test.sv
